### hw/rtl/cmwc_pkg.sv
// Shared types and constants for the CMWC random generator.
`default_nettype none

package cmwc_pkg;

  // Field widths of the request and response items
  localparam int OPCODE_W      = 2;
  localparam int TABLE_INDEX_W = 12;
  localparam int WORD_W        = 32;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_GENERATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESTART  = 2'd2;

  // Configuration port: two word registers, selected by paddr[REG_SEL_BIT]
  localparam int   PADDR_W           = 3;
  localparam int   REG_SEL_BIT       = 2;
  localparam logic REG_MULTIPLIER    = 1'b0;
  localparam logic REG_INITIAL_CARRY = 1'b1;

  // Reset values and the CMWC base constant
  localparam logic [WORD_W-1:0] MULTIPLIER_RESET = 32'd18782;
  localparam logic [WORD_W-1:0] CMWC_BASE        = 32'hffff_fffe;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

### hw/rtl/cmwc_ifs.sv
// Request and response channel interfaces of the CMWC random generator.
`default_nettype none

interface cmwc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] table_index;
  logic [31:0] table_value;

  modport source (output valid, output opcode, output table_index, output table_value,
                  input ready);
  modport sink   (input valid, input opcode, input table_index, input table_value,
                  output ready);
endinterface

interface cmwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

### hw/rtl/cmwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cmwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/cmwc_random_generator.sv
// Top level of the CMWC random generator: sequencer, shared multiply-add and lag table.
//
// Usage: requests arrive on req (valid/ready). A write item loads one lag table
// word, a restart item sets the lag position to the last entry and loads the
// carry from initial_carry, a generate item runs STEPS_PER_OUTPUT lag steps and
// returns the last stored word as one item on rsp. Write and restart items
// complete as they are accepted and give no response; unused opcodes are dropped.
// Each lag step runs through one shared 32x32 multiplier and one 64-bit adder:
// multiply, add carry, then fold and store, with the next table read overlapped
// with the store. A generate item passes a read state and then these steps in turn;
// the response is raised as the final step stores, and req is ready again in the
// same cycle; the carry chain between steps keeps the steps from overlapping.
// The response sits in an output register; further write and restart items are
// taken while it waits. If the receiver stalls, the next generate item holds
// in its final step until the previous response is taken.
// Reset clears the carry, sets the position to the last entry and the
// multiplier to 18782. Table contents are undefined until written; there is no
// clearing pass. Write registers multiplier (0x0) and initial_carry (0x4) over
// the APB port only while the block is idle; the block does not enforce this.
`default_nettype none

module cmwc_random_generator import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH      = 4096,
  parameter int STEPS_PER_OUTPUT = 5
) (
  input  logic               clk,
  input  logic               rst,
  cmwc_in_if.sink            req,
  cmwc_out_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output logic [WORD_W-1:0]  prdata,
  output logic               pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = (STEPS_PER_OUTPUT > 1) ? $clog2(STEPS_PER_OUTPUT) : 1;
  localparam int CW = ((AW > TABLE_INDEX_W) ? AW : TABLE_INDEX_W) + 1;
  localparam logic [AW-1:0] LAST_POS  = AW'(TABLE_DEPTH - 1);
  localparam logic [SW-1:0] LAST_STEP = SW'(STEPS_PER_OUTPUT - 1);

  state_t                  state;
  logic [AW-1:0]           pos;
  logic [AW-1:0]           pos_inc;
  logic [WORD_W-1:0]       carry;
  logic [SW-1:0]           step;
  logic [WORD_W-1:0]       multiplier;
  logic [WORD_W-1:0]       initial_carry;
  logic                    rsp_valid;
  logic [WORD_W-1:0]       out_word;
  logic [2*WORD_W-1:0]     prod;
  logic [2*WORD_W-1:0]     sum_t;

  logic                    accept;
  logic                    cfg_write;
  logic                    idx_ok;
  logic                    last_step;
  logic                    fin_go;
  logic [WORD_W-1:0]       fold_carry;
  logic [WORD_W:0]         fold_sum;
  logic [WORD_W-1:0]       x_word;
  logic [WORD_W-1:0]       carry_next;
  logic [WORD_W-1:0]       new_word;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WORD_W-1:0]       ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;

  // Handshakes
  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = rsp_valid;
  assign rsp.random_word = out_word;
  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;

  // Position advance, wrapping at the table depth
  assign pos_inc   = (pos == LAST_POS) ? '0 : pos + 1'b1;
  assign idx_ok    = CW'(req.table_index) < CW'(TABLE_DEPTH);
  assign last_step = (step == LAST_STEP);
  // Hold the final step while a previous response still waits
  assign fin_go    = !last_step || !rsp_valid || rsp.ready;

  // Fold the 64-bit sum into the next word and carry
  always_comb begin
    fold_carry = sum_t[2*WORD_W-1:WORD_W];
    fold_sum   = {1'b0, sum_t[WORD_W-1:0]} + {1'b0, fold_carry};
    x_word     = fold_sum[WORD_W-1:0] + WORD_W'(fold_sum[WORD_W]);
    carry_next = fold_carry + WORD_W'(fold_sum[WORD_W]);
    new_word   = CMWC_BASE - x_word;
  end

  // Table write port: generation stores take the port in the fold state
  always_comb begin
    if (state == ST_FIN) begin
      ram_we    = fin_go;
      ram_waddr = pos;
      ram_wdata = new_word;
    end else begin
      ram_we    = accept && (req.opcode == OP_WRITE) && idx_ok;
      ram_waddr = AW'(req.table_index);
      ram_wdata = req.table_value;
    end
  end

  cmwc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_lag_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_inc),
    .rdata (ram_rdata)
  );

  // Register read-back
  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_MULTIPLIER:    prdata = multiplier;
      REG_INITIAL_CARRY: prdata = initial_carry;
      default:           prdata = '0;
    endcase
  end

  // Shared multiplier and adder datapath
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= {{WORD_W{1'b0}}, multiplier} * {{WORD_W{1'b0}}, ram_rdata};
    end
    if (state == ST_ADD) begin
      sum_t <= prod + {{WORD_W{1'b0}}, carry};
    end
    if ((state == ST_FIN) && fin_go && last_step) begin
      out_word <= new_word;
    end
  end

  // Sequencer, configuration and response control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pos           <= LAST_POS;
      carry         <= '0;
      step          <= '0;
      rsp_valid     <= 1'b0;
      multiplier    <= MULTIPLIER_RESET;
      initial_carry <= '0;
    end else begin
      if (cfg_write) begin
        if (paddr[REG_SEL_BIT] == REG_MULTIPLIER) begin
          multiplier <= pwdata;
        end else begin
          initial_carry <= pwdata;
        end
      end

      // Raise the response as the final step stores, drop it once taken
      if ((state == ST_FIN) && fin_go && last_step) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && (req.opcode == OP_GENERATE)) begin
            step  <= '0;
            state <= ST_READ;
          end else if (accept && (req.opcode == OP_RESTART)) begin
            pos   <= LAST_POS;
            carry <= initial_carry;
          end
        end
        ST_READ: begin
          pos   <= pos_inc;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ADD;
        end
        ST_ADD: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            carry <= carry_next;
            if (last_step) begin
              state <= ST_IDLE;
            end else begin
              step  <= step + 1'b1;
              pos   <= pos_inc;
              state <= ST_MUL;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cmwc_checker.sv
// Port-level checker for the CMWC random generator, bound to the top level.
`default_nettype none

module cmwc_checker import cmwc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic [OPCODE_W-1:0]      req_opcode,
  input logic                     rsp_valid,
  input logic                     rsp_ready
);

  logic req_accept;
  assign req_accept = req_valid && req_ready;

  // Hold a response until it is taken
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // Drop ready while a generate item is at work
  assert property (@(posedge clk) disable iff (rst)
    req_accept && (req_opcode == OP_GENERATE) |=> !req_ready)
    else $error("ready high right after a generate item");

  // Keep ready after write, restart and unused items
  assert property (@(posedge clk) disable iff (rst)
    req_accept && (req_opcode != OP_GENERATE) |=> req_ready)
    else $error("ready dropped after a write or restart item");

  // Raise a response only as a generate item finishes
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response appeared while the block was idle");

endmodule

bind cmwc_random_generator cmwc_checker u_cmwc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_opcode (req.opcode),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready)
);

`default_nettype wire

### dv/cmwc_word_checker.sv
// Checker for the CMWC random generator: tracks the lag table and scores every random word.
`timescale 1ns / 100ps

module cmwc_word_checker import cmwc_pkg::*; #(
  parameter int TABLE_DEPTH      = 4096,
  parameter int STEPS_PER_OUTPUT = 5
) (
  input  logic               clk,
  input  logic               rst,
  cmwc_in_if                 req,
  cmwc_out_if                rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0]  pwdata,
  output int unsigned        mismatches,
  output int unsigned        words_pending
);

  // Shadow copy of the generator state and its two registers
  logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
  int unsigned       lag_pos;
  logic [WORD_W-1:0] carry;
  logic [WORD_W-1:0] multiplier;
  logic [WORD_W-1:0] carry_seed;

  // Random words still owed by the block, oldest first
  logic [WORD_W-1:0] owed_words [$];
  int unsigned       fail_total;

  // One lag step: advance, multiply-add, fold the carry back in, store the complement
  task automatic lag_step(output logic [WORD_W-1:0] stored);
    logic [63:0]       product;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] x;
    lag_pos = (lag_pos + 1) % TABLE_DEPTH;
    product = 64'(multiplier) * 64'(lag_words[lag_pos]) + 64'(carry);
    c = product[63:32];
    x = product[31:0] + c;
    if (x < c) begin
      x = x + 1'b1;
      c = c + 1'b1;
    end
    carry = c;
    stored = CMWC_BASE - x;
    lag_words[lag_pos] = stored;
  endtask

  // Apply one accepted request to the shadow state
  task automatic apply_request(input logic [OPCODE_W-1:0] op,
                               input logic [TABLE_INDEX_W-1:0] idx,
                               input logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] last;
    case (op)
      OP_WRITE: begin
        if (idx < TABLE_DEPTH) lag_words[idx] = val;
      end
      OP_GENERATE: begin
        last = '0;
        for (int k = 0; k < STEPS_PER_OUTPUT; k++) lag_step(last);
        owed_words.push_back(last);
      end
      OP_RESTART: begin
        lag_pos = TABLE_DEPTH - 1;
        carry = carry_seed;
      end
      default: ;  // unused opcode: drop
    endcase
  endtask

  // Compare one delivered word with the oldest one owed
  task automatic check_word(input logic [WORD_W-1:0] got);
    logic [WORD_W-1:0] want;
    if (owed_words.size() == 0) begin
      $display("%0t: random_word %h delivered with none expected", $time, got);
      fail_total++;
    end else begin
      want = owed_words.pop_front();
      if (got !== want) begin
        $display("%0t: random_word expected %h actual %h", $time, want, got);
        fail_total++;
      end
    end
  endtask

  // Watch register writes, responses and requests at each edge
  always @(posedge clk) begin
    if (rst) begin
      lag_pos = TABLE_DEPTH - 1;
      carry = '0;
      multiplier = MULTIPLIER_RESET;
      carry_seed = '0;
      owed_words.delete();
      foreach (lag_words[i]) lag_words[i] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[REG_SEL_BIT] == REG_MULTIPLIER) multiplier = pwdata;
        else carry_seed = pwdata;
      end
      // score the response before a request of the same edge can add to the queue
      if (rsp.valid && rsp.ready) check_word(rsp.random_word);
      if (req.valid && req.ready) apply_request(req.opcode, req.table_index, req.table_value);
    end
    mismatches <= fail_total;
    words_pending <= owed_words.size();
  end

endmodule

### dv/tb_cmwc_random_generator.sv
// Testbench top for the CMWC random generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_cmwc_random_generator import cmwc_pkg::*;;

  localparam int TABLE_DEPTH      = 4096;
  localparam int STEPS_PER_OUTPUT = 5;
  localparam int IDLE_PERCENT     = 36;
  localparam int SETTLE_CYCLES    = 4;
  localparam int TAIL_CYCLES      = 3 * STEPS_PER_OUTPUT + 5;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [WORD_W-1:0]   pwdata;
  logic [WORD_W-1:0]   prdata;
  logic                pready;
  logic                no_gaps;
  int unsigned         mismatches;
  int unsigned         words_pending;

  // Stimulus bookkeeping: which entries hold a word, and where the lag position stands
  bit                  entry_loaded [TABLE_DEPTH];
  int unsigned         lag_cursor;
  int unsigned         items_sent;

  cmwc_in_if  req_if ();
  cmwc_out_if rsp_if ();

  cmwc_random_generator #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .STEPS_PER_OUTPUT (STEPS_PER_OUTPUT)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cmwc_word_checker #(
    .TABLE_DEPTH      (TABLE_DEPTH),
    .STEPS_PER_OUTPUT (STEPS_PER_OUTPUT)
  ) u_word_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_if),
    .rsp           (rsp_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Seed words lean towards the extremes
  function automatic logic [WORD_W-1:0] seed_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return WORD_W'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  // Offer one item, idling at random first, and hold it until taken
  task automatic send_item(input logic [OPCODE_W-1:0] op,
                           input logic [TABLE_INDEX_W-1:0] idx,
                           input logic [WORD_W-1:0] val);
    while (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.table_index <= idx;
    req_if.table_value <= val;
    do @(posedge clk); while (!req_if.ready);
    case (op)
      OP_WRITE:    entry_loaded[idx] = 1'b1;
      OP_GENERATE: lag_cursor = (lag_cursor + STEPS_PER_OUTPUT) % TABLE_DEPTH;
      OP_RESTART:  lag_cursor = TABLE_DEPTH - 1;
      default: ;
    endcase
    items_sent++;
  endtask

  // Load any entry the next generate would read, then ask for a word
  task automatic request_word();
    int unsigned slot;
    for (int k = 1; k <= STEPS_PER_OUTPUT; k++) begin
      slot = (lag_cursor + k) % TABLE_DEPTH;
      if (!entry_loaded[slot]) send_item(OP_WRITE, TABLE_INDEX_W'(slot), seed_word());
    end
    send_item(OP_GENERATE, TABLE_INDEX_W'($urandom()), $urandom());
  endtask

  // Drop valid, wait for every owed word, then let the block go quiet
  task automatic settle(input int unsigned extra);
    req_if.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Write both registers over the APB port
  task automatic configure(input logic [WORD_W-1:0] mult, input logic [WORD_W-1:0] seed);
    logic [PADDR_W-1:0] addr;
    logic [WORD_W-1:0]  value;
    for (int r = 0; r < 2; r++) begin
      addr = '0;
      addr[REG_SEL_BIT] = (r == 0) ? REG_MULTIPLIER : REG_INITIAL_CARRY;
      value = (r == 0) ? mult : seed;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly generate items, with stray writes, restarts and unused opcodes mixed in
  task automatic random_phase(input int unsigned budget, input bit allow_restart);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 62)
        request_word();
      else if (pick < 82)
        send_item(OP_WRITE, TABLE_INDEX_W'($urandom()), seed_word());
      else if (pick < 94 && allow_restart)
        send_item(OP_RESTART, TABLE_INDEX_W'($urandom()), $urandom());
      else if (pick >= 94)
        send_item(OP_UNUSED, TABLE_INDEX_W'($urandom()), $urandom());
      else
        request_word();
    end
  endtask

  // Receiver: stall at random except during the steady stretch
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("tb_cmwc_random_generator NOT OK");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_WRITE;
    req_if.table_index <= '0;
    req_if.table_value <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    no_gaps            <= 1'b0;
    lag_cursor = TABLE_DEPTH - 1;
    items_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme seeds, unused opcode, wrap from the last entry, restart
    send_item(OP_WRITE, '0, '1);
    send_item(OP_WRITE, 12'd1, '0);
    send_item(OP_WRITE, 12'd2, 32'h8000_0000);
    send_item(OP_WRITE, 12'd3, 32'h0000_0001);
    send_item(OP_WRITE, 12'd4, CMWC_BASE);
    send_item(OP_WRITE, '1, '1);
    // an unused opcode must not touch entry 0, which the next generate reads
    send_item(OP_UNUSED, '0, 32'h5a5a_5a5a);
    request_word();
    request_word();
    send_item(OP_RESTART, '1, '1);
    request_word();
    send_item(OP_WRITE, '0, '0);
    send_item(OP_RESTART, '0, '0);
    request_word();
    settle(SETTLE_CYCLES);

    // Random phases over several register settings
    random_phase(180, 1'b1);
    settle(SETTLE_CYCLES);
    configure('1, 32'hffff_fffe);
    random_phase(150, 1'b1);
    settle(SETTLE_CYCLES);
    configure(32'd1, '0);
    random_phase(120, 1'b1);
    settle(SETTLE_CYCLES);
    // zero multiplier and a carry far above it are taken as given
    configure('0, '1);
    random_phase(100, 1'b1);
    settle(SETTLE_CYCLES);
    configure($urandom(), $urandom());
    no_gaps <= 1'b1;
    random_phase(150, 1'b1);
    settle(SETTLE_CYCLES);
    no_gaps <= 1'b0;
    // long run without restarts walks the position deep into the table
    configure(MULTIPLIER_RESET, MULTIPLIER_RESET - 1'b1);
    random_phase(230, 1'b0);
    settle(TAIL_CYCLES);

    if (mismatches == 0 && words_pending == 0) begin
      $display("tb_cmwc_random_generator OK");
    end else begin
      $display("tb_cmwc_random_generator NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cmwc_pkg.sv
hw/rtl/cmwc_ifs.sv
hw/rtl/cmwc_ram.sv
hw/rtl/cmwc_random_generator.sv
hw/rtl/cmwc_checker.sv
dv/cmwc_word_checker.sv
dv/tb_cmwc_random_generator.sv
